/* hdl/moving_average_deviation_signal_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the moving average deviation signal block
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_DEVIATION_SIGNAL_ASSERT_SVH
`define MOVING_AVERAGE_DEVIATION_SIGNAL_ASSERT_SVH

`ifndef SYNTHESIS

`define MADS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define MADS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MADS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MADS_ASSERT_ALWAYS(lbl, cond, msg)

`define MADS_ASSERT_IMP(lbl, ante, cons, msg)

`define MADS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/mads_pkg.sv */
// ----------------------------------------------------------------------------
// mads_pkg
// Shared constants, codes and types of the moving average deviation block.
// ----------------------------------------------------------------------------
package mads_pkg;

    localparam int DEF_MAX_LOOKBACK = 64;
    localparam int DEF_PRICE_BITS   = 32;

    localparam int PRICE_IN_W = 32;
    localparam int LB_W       = 7;
    localparam int THR_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int MEAN_W     = 32;
    localparam int SIG_W      = 2;
    localparam int Q_FRAC     = 16;
    localparam int DIV_STEP   = 8;
    localparam int Q_DEPTH    = 2;

    localparam int OUT_W      = SIG_W + MEAN_W + PRICE_IN_W;
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    localparam logic [LB_W-1:0]  LOOKBACK_RESET  = 7'd20;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 24'd3277;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOOKBACK  = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic [SIG_W-1:0] {
        SIG_NEUTRAL = 2'd0,
        SIG_BUY     = 2'd1,
        SIG_SELL    = 2'd2
    } signal_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hdl/mads_ram.sv */
// ----------------------------------------------------------------------------
// mads_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mads_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mads_fifo.sv */
// ----------------------------------------------------------------------------
// mads_fifo
// Short request queue between the window front end and the compare back end.
// ----------------------------------------------------------------------------
module mads_fifo
    import mads_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == Q_DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(Q_DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

/* hdl/mads_front.sv */
// ----------------------------------------------------------------------------
// mads_front
// Takes prices, keeps the price ring and running sum, queues compare requests.
// ----------------------------------------------------------------------------
`include "moving_average_deviation_signal_assert.svh"

module mads_front
    import mads_pkg::*;
#(
    parameter int MAX_LOOKBACK = DEF_MAX_LOOKBACK,
    parameter int PRICE_BITS   = DEF_PRICE_BITS,
    localparam int LEN_W = $clog2(MAX_LOOKBACK + 1),
    localparam int P_W   = (PRICE_BITS < PRICE_IN_W) ? PRICE_BITS : PRICE_IN_W,
    localparam int SUM_W = P_W + $clog2(MAX_LOOKBACK),
    localparam int JOB_W = 1 + LEN_W + SUM_W + P_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PRICE_IN_W-1:0] s_tdata,
    input  logic [LEN_W-1:0]      win_len,
    input  logic                  win_clear,
    output logic                  push,
    output logic [JOB_W-1:0]      push_data,
    input  q_status_t             q_status
);

    localparam int PTR_W = (MAX_LOOKBACK > 1) ? $clog2(MAX_LOOKBACK) : 1;

    typedef enum logic {ST_IDLE, ST_UPD} state_t;

    state_t           state_reg;
    logic [P_W-1:0]   price_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [PTR_W-1:0] ptr_reg;

    logic [PTR_W-1:0] ptr_cur;
    logic [LEN_W-1:0] ptr_inc;
    logic             full_cur;
    logic             accept;
    logic             upd_go;
    logic [P_W-1:0]   ring_rdata;
    logic [SUM_W-1:0] sum_sub;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ptr_cur  = (LEN_W'(ptr_reg) >= win_len) ? '0 : ptr_reg;
    assign ptr_inc  = LEN_W'(ptr_cur) + LEN_W'(1);
    assign full_cur = (fill_reg >= win_len);
    assign upd_go   = (state_reg == ST_UPD) && !q_status.full;
    assign sum_sub  = full_cur ? SUM_W'(ring_rdata) : '0;

    assign push      = upd_go;
    assign push_data = {full_cur, win_len, sum_reg, price_reg};

    mads_ram #(
        .WIDTH (P_W),
        .DEPTH (MAX_LOOKBACK)
    ) u_ring (
        .clk   (clk),
        .we    (upd_go),
        .waddr (ptr_cur),
        .wdata (price_reg),
        .re    (accept),
        .raddr (ptr_cur),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            fill_reg  <= '0;
            ptr_reg   <= '0;
        end
        else if (win_clear)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if (!q_status.full)
                    begin
                        sum_reg <= sum_reg - sum_sub + SUM_W'(price_reg);
                        if (!full_cur)
                        begin
                            fill_reg <= fill_reg + LEN_W'(1);
                        end
                        ptr_reg   <= (ptr_inc >= win_len) ? '0 : ptr_inc[PTR_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            price_reg <= s_tdata[P_W-1:0];
        end
    end

    `MADS_ASSERT_ALWAYS(a_ptr_in_window, LEN_W'(ptr_reg) < win_len, "ring pointer out of window")
    `MADS_ASSERT_ALWAYS(a_fill_bounded, fill_reg <= win_len, "fill count above window length")

endmodule

/* hdl/mads_back.sv */
// ----------------------------------------------------------------------------
// mads_back
// Runs the deviation compare and the mean divide for each queued request.
// ----------------------------------------------------------------------------
`include "moving_average_deviation_signal_assert.svh"

module mads_back
    import mads_pkg::*;
#(
    parameter int MAX_LOOKBACK = DEF_MAX_LOOKBACK,
    parameter int PRICE_BITS   = DEF_PRICE_BITS,
    localparam int LEN_W = $clog2(MAX_LOOKBACK + 1),
    localparam int P_W   = (PRICE_BITS < PRICE_IN_W) ? PRICE_BITS : PRICE_IN_W,
    localparam int SUM_W = P_W + $clog2(MAX_LOOKBACK),
    localparam int JOB_W = 1 + LEN_W + SUM_W + P_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_status_t             q_status,
    output logic                  pop,
    input  logic [JOB_W-1:0]      pop_data,
    input  logic [THR_W-1:0]      thr,
    output logic                  out_valid,
    input  logic                  out_ready,
    output signal_t               out_signal,
    output logic [MEAN_W-1:0]     out_mean,
    output logic [PRICE_IN_W-1:0] out_price,
    output logic                  out_full
);

    localparam int PL_W      = P_W + LEN_W;
    localparam int H         = (SUM_W + 1) / 2;
    localparam int HI_W      = SUM_W - H;
    localparam int TS_W      = THR_W + SUM_W;
    localparam int DIV_ITERS = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W     = DIV_ITERS * DIV_STEP;
    localparam int RUN_CYC   = (DIV_ITERS > 4) ? DIV_ITERS : 4;
    localparam int CNT_W     = $clog2(RUN_CYC);

    localparam logic [CNT_W-1:0] PH_PL    = CNT_W'(0);
    localparam logic [CNT_W-1:0] PH_LO    = CNT_W'(1);
    localparam logic [CNT_W-1:0] PH_HI    = CNT_W'(2);
    localparam logic [CNT_W-1:0] PH_CMP   = CNT_W'(3);
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(RUN_CYC - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      run_cnt_reg;
    logic                  out_valid_reg;

    logic [P_W-1:0]        price_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  full_reg;
    logic [SUM_W-1:0]      pl_reg;
    logic [SUM_W-1:0]      dev_reg;
    logic                  lt_reg;
    logic [THR_W+H-1:0]    plo_reg;
    logic [THR_W+HI_W-1:0] phi_reg;
    signal_t               sig_reg;
    logic [DIV_W-1:0]      num_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [LEN_W-1:0]      rem_reg;

    signal_t               out_sig_reg;
    logic [MEAN_W-1:0]     out_mean_reg;
    logic [PRICE_IN_W-1:0] out_price_reg;
    logic                  out_full_reg;

    logic                  j_full;
    logic [LEN_W-1:0]      j_len;
    logic [SUM_W-1:0]      j_sum;
    logic [P_W-1:0]        j_price;

    logic [PL_W-1:0]       pl_prod;
    logic [THR_W+H-1:0]    plo_prod;
    logic [THR_W+HI_W-1:0] phi_prod;
    logic [TS_W-1:0]       ts_val;
    logic [TS_W-1:0]       dev_scaled;
    logic                  dev_ge;
    signal_t               sig_calc;
    logic [LEN_W-1:0]      rem_step;
    logic [DIV_STEP-1:0]   qbits_step;
    logic                  div_active;
    logic                  done_go;
    logic [MEAN_W-1:0]     mean_gated;

    assign {j_full, j_len, j_sum, j_price} = pop_data;

    assign pop        = (state_reg == ST_IDLE) && !q_status.empty;
    assign div_active = ({1'b0, run_cnt_reg} < (CNT_W + 1)'(DIV_ITERS));
    assign done_go    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign pl_prod  = PL_W'(price_reg) * PL_W'(len_reg);
    assign plo_prod = (THR_W + H)'(thr) * (THR_W + H)'(sum_reg[H-1:0]);
    assign phi_prod = (THR_W + HI_W)'(thr) * (THR_W + HI_W)'(sum_reg[SUM_W-1:H]);

    assign ts_val     = TS_W'(plo_reg) + (TS_W'(phi_reg) << H);
    assign dev_scaled = TS_W'({dev_reg, {Q_FRAC{1'b0}}});
    assign dev_ge     = (dev_scaled >= ts_val);

    always_comb
    begin
        if (!full_reg || (sum_reg == '0))
        begin
            sig_calc = SIG_NEUTRAL;
        end
        else if (lt_reg)
        begin
            sig_calc = dev_ge ? SIG_BUY : SIG_NEUTRAL;
        end
        else if ((dev_reg == '0) && (thr == '0))
        begin
            // price on the mean with a zero band counts as a buy
            sig_calc = SIG_BUY;
        end
        else
        begin
            sig_calc = dev_ge ? SIG_SELL : SIG_NEUTRAL;
        end
    end

    // restoring divide, DIV_STEP quotient bits per cycle
    always_comb
    begin : div_step
        logic [LEN_W:0]      r_ext;
        logic [LEN_W-1:0]    r;
        logic [DIV_STEP-1:0] qb;
        r     = rem_reg;
        qb    = '0;
        r_ext = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            r_ext = {r, num_reg[DIV_W-1-i]};
            if (r_ext >= {1'b0, len_reg})
            begin
                r_ext = r_ext - {1'b0, len_reg};
                qb[DIV_STEP-1-i] = 1'b1;
            end
            r = r_ext[LEN_W-1:0];
        end
        rem_step   = r;
        qbits_step = qb;
    end

    assign mean_gated = (full_reg && (sum_reg != '0)) ? MEAN_W'(quo_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg   <= ST_RUN;
                        run_cnt_reg <= '0;
                    end
                end
                ST_RUN:
                begin
                    run_cnt_reg <= run_cnt_reg + CNT_W'(1);
                    if (run_cnt_reg == RUN_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (done_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            price_reg <= j_price;
            sum_reg   <= j_sum;
            len_reg   <= j_len;
            full_reg  <= j_full;
            num_reg   <= DIV_W'(j_sum);
            rem_reg   <= '0;
            quo_reg   <= '0;
        end

        if (state_reg == ST_RUN)
        begin
            if (div_active)
            begin
                num_reg <= num_reg << DIV_STEP;
                quo_reg <= (quo_reg << DIV_STEP) | DIV_W'(qbits_step);
                rem_reg <= rem_step;
            end
            case (run_cnt_reg)
                PH_PL:
                begin
                    pl_reg <= pl_prod[SUM_W-1:0];
                end
                PH_LO:
                begin
                    plo_reg <= plo_prod;
                    lt_reg  <= (pl_reg < sum_reg);
                    dev_reg <= (pl_reg < sum_reg) ? (sum_reg - pl_reg) : (pl_reg - sum_reg);
                end
                PH_HI:
                begin
                    phi_reg <= phi_prod;
                end
                PH_CMP:
                begin
                    sig_reg <= sig_calc;
                end
                default:
                begin
                end
            endcase
        end

        if (done_go)
        begin
            out_sig_reg   <= sig_reg;
            out_mean_reg  <= mean_gated;
            out_price_reg <= PRICE_IN_W'(price_reg);
            out_full_reg  <= full_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_signal = out_sig_reg;
    assign out_mean   = out_mean_reg;
    assign out_price  = out_price_reg;
    assign out_full   = out_full_reg;

    `MADS_ASSERT_IMP(a_rem_below_len, state_reg == ST_RUN, rem_reg < len_reg, "divider remainder not below divisor")
    `MADS_ASSERT_NEXT(a_result_loaded, done_go, out_valid_reg && (state_reg == ST_IDLE), "result not loaded")
    `MADS_ASSERT_IMP(a_warmup_neutral, out_valid_reg && !out_full_reg, (out_sig_reg == SIG_NEUTRAL) && (out_mean_reg == '0), "warm-up result not neutral")

endmodule

/* hdl/moving_average_deviation_signal.sv */
// ----------------------------------------------------------------------------
// moving_average_deviation_signal
// Simple moving average deviation threshold: buy / sell / neutral per price.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one price per request in s_tdata[31:0].
//   m_* returns one result per price: m_tdata holds signal, window mean and
//   the echoed price; m_tuser flags that a full window of earlier prices
//   existed. Results come out in input order.
//   cfg_we / cfg_addr / cfg_wdata write lookback (0) and threshold_q16 (1);
//   writing lookback empties the window. Write only while the block is idle.
// Flow: the front end takes a new price only after it has queued the last one;
//   the back end works through one request at a time in its run and done states,
//   so its result rate is set by the radix-256 mean divider.
// Reset: window empty, lookback 20, threshold 3277, no result pending.
// A stalled m_tready holds the result; the back end finishes its next request,
//   the 2-deep queue fills, then s_tready stays low.
// ----------------------------------------------------------------------------
module moving_average_deviation_signal
    import mads_pkg::*;
#(
    parameter int MAX_LOOKBACK = DEF_MAX_LOOKBACK,
    parameter int PRICE_BITS   = DEF_PRICE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PRICE_IN_W-1:0] s_tdata,   // [31:0] price
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] signal, [33:2] window_mean,
                                             // [65:34] order_price, rest zero
    output logic [0:0]            m_tuser,   // [0] window_full
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LEN_W = $clog2(MAX_LOOKBACK + 1);
    localparam int P_W   = (PRICE_BITS < PRICE_IN_W) ? PRICE_BITS : PRICE_IN_W;
    localparam int SUM_W = P_W + $clog2(MAX_LOOKBACK);
    localparam int JOB_W = 1 + LEN_W + SUM_W + P_W;

    logic [LB_W-1:0]  lookback_reg;
    logic [THR_W-1:0] thr_reg;
    logic [LEN_W-1:0] win_len;
    logic             win_clear;

    logic             q_push;
    logic [JOB_W-1:0] q_push_data;
    logic             q_pop;
    logic [JOB_W-1:0] q_pop_data;
    q_status_t        q_status;

    signal_t               out_signal;
    logic [MEAN_W-1:0]     out_mean;
    logic [PRICE_IN_W-1:0] out_price;
    logic                  out_full;

    assign win_clear = cfg_we && (cfg_reg_t'(cfg_addr) == REG_LOOKBACK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookback_reg <= LOOKBACK_RESET;
            thr_reg      <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_LOOKBACK:  lookback_reg <= cfg_wdata[LB_W-1:0];
                REG_THRESHOLD: thr_reg      <= cfg_wdata[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the ring depth acts as the depth
    always_comb
    begin
        if (lookback_reg == '0)
        begin
            win_len = LEN_W'(1);
        end
        else if (32'(lookback_reg) > MAX_LOOKBACK)
        begin
            win_len = LEN_W'(MAX_LOOKBACK);
        end
        else
        begin
            win_len = LEN_W'(lookback_reg);
        end
    end

    mads_front #(
        .MAX_LOOKBACK (MAX_LOOKBACK),
        .PRICE_BITS   (PRICE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .win_len   (win_len),
        .win_clear (win_clear),
        .push      (q_push),
        .push_data (q_push_data),
        .q_status  (q_status)
    );

    mads_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    mads_back #(
        .MAX_LOOKBACK (MAX_LOOKBACK),
        .PRICE_BITS   (PRICE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop        (q_pop),
        .pop_data   (q_pop_data),
        .thr        (thr_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_signal (out_signal),
        .out_mean   (out_mean),
        .out_price  (out_price),
        .out_full   (out_full)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, out_price, out_mean, out_signal};
    assign m_tuser = out_full;

endmodule
